// ----- rtl/core/pulse_shape_analyzer_core_macros.svh -----
// Assertion macros shared by the pulse shape analyser RTL.
// Included by files that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef PULSE_SHAPE_ANALYZER_CORE_MACROS_SVH
`define PULSE_SHAPE_ANALYZER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/psa_pkg.sv -----
// Types and constants for the pulse shape analyser.
// No dependencies; used by psa_store, psa_arith and pulse_shape_analyzer_core.
package psa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PRE_W    = 11;
    localparam int SUM_W    = 26;
    localparam int SQ_W     = 42;
    localparam int FIELD_W  = 10;
    localparam int RMS_W    = 19;
    localparam int STAT_W   = 3;
    localparam int ARITH_W  = 64;
    localparam int MULB_W   = 32;
    localparam int DIVQ_W   = 22;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_RISE_OFF = 3'd1;
    localparam logic [STAT_W-1:0] ST_DECAY_OFF = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_PEAK  = 3'd3;
    localparam logic [STAT_W-1:0] ST_PRE_BIG  = 3'd4;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_arith_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_st;

    // Exact threshold test: 10*x < k*peak, k is 9 or 3
    function automatic logic f_below(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] p,
                                     logic nine);
        logic [SAMPLE_W+3:0] lhs;
        logic [SAMPLE_W+3:0] rhs;
        lhs = {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
        if (nine) begin
            rhs = {1'b0, p, 3'b000} + {4'b0000, p};
        end else begin
            rhs = {3'b000, p, 1'b0} + {4'b0000, p};
        end
        return lhs < rhs;
    endfunction

endpackage

// ----- rtl/core/pulse_shape_analyzer_core.sv -----
// Pulse shape analyser top level: sequencer, window accumulators and output register.
// Uses psa_pkg, psa_store, psa_arith and the assertion macro header.
//
// Samples load at one per cycle while s_axis_tready is high. After the word
// with tlast the block stops taking samples: each sample visited by the rise
// and decay walks costs one memory read and one compare, plus one
// extra compare at each 90 % crossing. The noise RMS then runs on the shared
// iterative unit: three 32-step multiplies, a 64-step divide and a 32-step
// square root. The result word is held on m_axis until taken; the next window
// loads after that. Pretrigger register writes are accepted in any cycle.
`include "pulse_shape_analyzer_core_macros.svh"
module pulse_shape_analyzer_core #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: sample[15:0]
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: peak_index[9:0], peak_value[25:10], rise_points[35:26],
    //        decay_points[45:36], noise_rms[64:46], zero pad[71:65]
    output logic [71:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (CNT_W > psa_pkg::PRE_W) ? CNT_W : psa_pkg::PRE_W;
    localparam int SW    = psa_pkg::SAMPLE_W;
    localparam int AW    = psa_pkg::ARITH_W;

    typedef enum logic [5:0] {
        S_LOAD    = 6'b000001,
        S_RD      = 6'b000010,
        S_CMP     = 6'b000100,
        S_AR_GO   = 6'b001000,
        S_AR_WAIT = 6'b010000,
        S_OUT     = 6'b100000
    } t_state;

    t_state                         r_state, n_state;
    logic [psa_pkg::PRE_W-1:0]      r_pretrig;
    logic [psa_pkg::PRE_W-1:0]      r_np;
    logic [CNT_W-1:0]               r_count;
    logic [SW-1:0]                  r_peak;
    logic [IDX_W-1:0]               r_pidx;
    logic [psa_pkg::SUM_W-1:0]      r_sum;
    logic [psa_pkg::SQ_W-1:0]       r_sq;
    logic [CNT_W-1:0]               r_pos;
    logic [CNT_W-1:0]               r_mark;
    logic                           r_dir;
    logic                           r_phase;
    logic [psa_pkg::STAT_W-1:0]     r_status;
    logic [psa_pkg::FIELD_W-1:0]    r_rise;
    logic [psa_pkg::FIELD_W-1:0]    r_decay;
    logic [psa_pkg::RMS_W-1:0]      r_rms;
    logic [AW-1:0]                  r_pa;
    logic [AW-1:0]                  r_d;
    logic [psa_pkg::DIVQ_W-1:0]     r_q;
    logic [2:0]                     r_astep;

    logic                           w_in_acc;
    logic                           w_room;
    logic                           w_in_pre;
    logic [SW-1:0]                  w_x;
    logic [2*SW-1:0]                w_sq;
    logic [SW-1:0]                  w_peak_new;
    logic [IDX_W-1:0]               w_pidx_new;
    logic [SW-1:0]                  w_rd;
    logic                           w_below;
    logic                           w_pre_bad;
    logic                           w_ok;
    psa_pkg::t_arith_ctl            w_actl;
    psa_pkg::t_arith_st             w_ast;
    logic [AW-1:0]                  w_aa;
    logic [psa_pkg::MULB_W-1:0]     w_ab;
    logic [AW-1:0]                  w_ares;

    // Input side
    assign s_axis_tready = (r_state == S_LOAD);
    assign o_cfg_ready   = 1'b1;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_x           = s_axis_tdata[SW-1:0];
    assign w_sq          = w_x * w_x;
    assign w_room        = r_count < CNT_W'(MAX_SAMPLES);
    assign w_in_pre      = CMP_W'(r_count) < CMP_W'(r_pretrig);

    // Peak including the word being accepted
    always_comb begin
        w_peak_new = r_peak;
        w_pidx_new = r_pidx;
        if (w_room && (w_x > r_peak)) begin
            w_peak_new = w_x;
            w_pidx_new = r_count[IDX_W-1:0];
        end
    end

    psa_store #(
        .DEPTH (MAX_SAMPLES),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_room),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_x),
        .i_raddr (r_pos[IDX_W-1:0]),
        .o_rdata (w_rd)
    );

    // Threshold test for the current walk phase
    assign w_below   = psa_pkg::f_below(w_rd, r_peak, !r_phase);
    assign w_pre_bad = CMP_W'(r_np) > CMP_W'(r_count);

    // Operand selection for the shared unit
    always_comb begin
        w_actl.start = (r_state == S_AR_GO);
        case (r_astep)
            3'd0: begin
                w_actl.op = psa_pkg::OP_MUL;
                w_aa = AW'(r_sq);
                w_ab = psa_pkg::MULB_W'(r_np);
            end
            3'd1: begin
                w_actl.op = psa_pkg::OP_MUL;
                w_aa = AW'(r_sum);
                w_ab = psa_pkg::MULB_W'(r_sum);
            end
            3'd2: begin
                w_actl.op = psa_pkg::OP_MUL;
                w_aa = AW'(r_np);
                w_ab = psa_pkg::MULB_W'(r_np);
            end
            3'd3: begin
                w_actl.op = psa_pkg::OP_DIV;
                w_aa = r_d;
                w_ab = psa_pkg::MULB_W'(r_q);
            end
            default: begin
                w_actl.op = psa_pkg::OP_SQRT;
                w_aa = r_pa;
                w_ab = '0;
            end
        endcase
    end

    psa_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_actl),
        .i_a      (w_aa),
        .i_b      (w_ab),
        .o_st     (w_ast),
        .o_result (w_ares)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc && s_axis_tlast) begin
                    n_state = (w_peak_new == '0) ? S_OUT : S_RD;
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (!w_below) begin
                    if (!r_dir) begin
                        n_state = (r_pos == '0) ? S_OUT : S_RD;
                    end else begin
                        n_state = (r_pos + 1'b1 >= r_count) ? S_OUT : S_RD;
                    end
                end else if (!r_phase) begin
                    n_state = S_CMP;
                end else if (!r_dir) begin
                    n_state = S_RD;
                end else if (w_pre_bad || (r_np == '0)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_AR_GO;
                end
            end
            S_AR_GO: n_state = S_AR_WAIT;
            S_AR_WAIT: begin
                if (w_ast.done) begin
                    n_state = (r_astep == 3'd4) ? S_OUT : S_AR_GO;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Window state, walks and arithmetic results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_pretrig <= psa_pkg::PRE_W'(16);
            r_count   <= '0;
            r_peak    <= '0;
            r_pidx    <= '0;
            r_sum     <= '0;
            r_sq      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_pretrig <= i_cfg_data;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_room) begin
                            r_peak  <= w_peak_new;
                            r_pidx  <= w_pidx_new;
                            r_count <= r_count + 1'b1;
                            if (w_in_pre) begin
                                r_sum <= r_sum + psa_pkg::SUM_W'(w_x);
                                r_sq  <= r_sq + psa_pkg::SQ_W'(w_sq);
                            end
                        end
                        if (s_axis_tlast) begin
                            r_np     <= r_pretrig;
                            r_pos    <= CNT_W'(w_pidx_new);
                            r_dir    <= 1'b0;
                            r_phase  <= 1'b0;
                            r_rise   <= '0;
                            r_decay  <= '0;
                            r_rms    <= '0;
                            r_status <= (w_peak_new == '0) ? psa_pkg::ST_NO_PEAK
                                                           : psa_pkg::ST_OK;
                        end
                    end
                end
                S_CMP: begin
                    if (!w_below) begin
                        if (!r_dir) begin
                            if (r_pos == '0) begin
                                r_status <= psa_pkg::ST_RISE_OFF;
                            end else begin
                                r_pos <= r_pos - 1'b1;
                            end
                        end else if (r_pos + 1'b1 >= r_count) begin
                            r_status <= psa_pkg::ST_DECAY_OFF;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end else if (!r_phase) begin
                        // 90 % crossing found; same sample is tested at 30 %
                        r_mark  <= r_pos;
                        r_phase <= 1'b1;
                    end else if (!r_dir) begin
                        r_rise  <= psa_pkg::FIELD_W'(r_mark - r_pos);
                        r_dir   <= 1'b1;
                        r_phase <= 1'b0;
                        r_pos   <= CNT_W'(r_pidx);
                    end else begin
                        r_decay <= psa_pkg::FIELD_W'(r_pos - r_mark);
                        r_astep <= 3'd0;
                        if (w_pre_bad) begin
                            r_status <= psa_pkg::ST_PRE_BIG;
                        end
                    end
                end
                S_AR_WAIT: begin
                    if (w_ast.done) begin
                        r_astep <= r_astep + 1'b1;
                        case (r_astep)
                            3'd0: r_pa <= w_ares;
                            3'd1: r_d  <= (r_pa > w_ares) ? ((r_pa - w_ares) << 8) : '0;
                            3'd2: r_q  <= w_ares[psa_pkg::DIVQ_W-1:0];
                            3'd3: r_pa <= w_ares;
                            default: begin
                                r_rms <= (w_ares > AW'({psa_pkg::RMS_W{1'b1}}))
                                       ? {psa_pkg::RMS_W{1'b1}}
                                       : w_ares[psa_pkg::RMS_W-1:0];
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_count <= '0;
                        r_peak  <= '0;
                        r_pidx  <= '0;
                        r_sum   <= '0;
                        r_sq    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result word; rise, decay and RMS fields read zero on any error
    assign w_ok          = (r_status == psa_pkg::ST_OK);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {7'b0000000,
                            w_ok ? r_rms   : {psa_pkg::RMS_W{1'b0}},
                            w_ok ? r_decay : {psa_pkg::FIELD_W{1'b0}},
                            w_ok ? r_rise  : {psa_pkg::FIELD_W{1'b0}},
                            r_peak,
                            psa_pkg::FIELD_W'(r_pidx)};

    `PSA_ASSERT_NOW(a_one_side, m_axis_tvalid, !s_axis_tready, "load and result overlap")
    `PSA_ASSERT_NOW(a_done_wait, w_ast.done, r_state == S_AR_WAIT, "arith done outside wait")
    `PSA_ASSERT_NEXT(a_clear, m_axis_tvalid && m_axis_tready,
                     (r_count == '0) && (r_peak == '0), "window not cleared after result")

endmodule

// ----- rtl/core/psa_store.sv -----
// Sample window memory: one write port, one registered read port.
// Uses psa_pkg; instantiated by pulse_shape_analyzer_core.
module psa_store #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [IDX_W-1:0]              i_waddr,
    input  logic [psa_pkg::SAMPLE_W-1:0]  i_wdata,
    input  logic [IDX_W-1:0]              i_raddr,
    output logic [psa_pkg::SAMPLE_W-1:0]  o_rdata
);

    logic [psa_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [psa_pkg::SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/psa_arith.sv -----
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
// Uses psa_pkg and the assertion macro header.
`include "pulse_shape_analyzer_core_macros.svh"
module psa_arith (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psa_pkg::t_arith_ctl          i_ctl,
    input  logic [psa_pkg::ARITH_W-1:0]  i_a,
    input  logic [psa_pkg::MULB_W-1:0]   i_b,
    output psa_pkg::t_arith_st           o_st,
    output logic [psa_pkg::ARITH_W-1:0]  o_result
);

    localparam int W   = psa_pkg::ARITH_W;
    localparam int BW  = psa_pkg::MULB_W;
    localparam int RW  = W + 2;
    localparam int CW  = $clog2(W + 1);

    logic            r_busy;
    logic            r_done;
    psa_pkg::t_op    r_op;
    logic [CW-1:0]   r_cnt;
    logic [W-1:0]    r_acc;
    logic [W-1:0]    r_x;
    logic [BW-1:0]   r_y;
    logic [RW-1:0]   r_rem;

    logic [RW-1:0]   w_rem2;
    logic [RW-1:0]   w_trial;
    logic            w_ge;

    // One step of the selected operation
    always_comb begin
        case (r_op)
            psa_pkg::OP_DIV: begin
                w_rem2  = {r_rem[RW-2:0], r_x[W-1]};
                w_trial = RW'(r_y);
            end
            psa_pkg::OP_SQRT: begin
                w_rem2  = {r_rem[RW-3:0], r_x[W-1:W-2]};
                w_trial = {r_acc, 2'b01};
            end
            default: begin
                w_rem2  = r_rem;
                w_trial = '0;
            end
        endcase
        w_ge = w_rem2 >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_acc  <= '0;
                r_rem  <= '0;
                r_x    <= i_a;
                r_y    <= i_b;
                case (i_ctl.op)
                    psa_pkg::OP_DIV:  r_cnt <= CW'(W);
                    psa_pkg::OP_SQRT: r_cnt <= CW'(W / 2);
                    default:          r_cnt <= CW'(BW);
                endcase
            end else if (r_busy) begin
                case (r_op)
                    psa_pkg::OP_DIV: begin
                        r_x   <= {r_x[W-2:0], 1'b0};
                        r_rem <= w_ge ? w_rem2 - w_trial : w_rem2;
                        r_acc <= {r_acc[W-2:0], w_ge};
                    end
                    psa_pkg::OP_SQRT: begin
                        r_x   <= {r_x[W-3:0], 2'b00};
                        r_rem <= w_ge ? w_rem2 - w_trial : w_rem2;
                        r_acc <= {r_acc[W-2:0], w_ge};
                    end
                    default: begin
                        if (r_y[0]) begin
                            r_acc <= r_acc + r_x;
                        end
                        r_x <= {r_x[W-2:0], 1'b0};
                        r_y <= {1'b0, r_y[BW-1:1]};
                    end
                endcase
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_done;
    assign o_result  = r_acc;

    `PSA_ASSERT_NOW(a_busy_cnt, r_busy, r_cnt != '0, "arith busy with zero count")
    `PSA_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "arith done longer than one cycle")

endmodule
